FILE: hdl/nfsa_pkg.sv
// Shared constants, request codes and control types of the next-fit slot allocator.
// No dependencies; every other file imports it.
package nfsa_pkg;

   localparam int SLOT_COUNT_DEF = 32;

   localparam int REQ_TYPE_W = 2;
   localparam int SLOT_IDX_W = 5;
   localparam int USED_CNT_W = 6;

   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // write command to the slot map
   typedef struct packed {
      logic en;
      logic set;
   } map_wr_type;

endpackage

FILE: hdl/nfsa_if.sv
// Request and response channel interfaces of the next-fit slot allocator.
// Depends on nfsa_pkg for the field widths.
interface nfsa_req_if import nfsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SLOT_IDX_W-1:0] slot_index;

   modport source (output valid, req_type, slot_index, input ready);
   modport sink   (input valid, req_type, slot_index, output ready);
endinterface

interface nfsa_rsp_if import nfsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [SLOT_IDX_W-1:0] granted_slot;
   logic                  slot_used;
   logic [USED_CNT_W-1:0] used_count;

   modport source (output valid, status, granted_slot, slot_used, used_count, input ready);
   modport sink   (input valid, status, granted_slot, slot_used, used_count, output ready);
endinterface

FILE: hdl/next_fit_slot_allocator_core.sv
// Next-fit slot allocator: request sequencer, search hint, used counter and
// response register. Depends on nfsa_pkg, nfsa_if.sv and nfsa_slot_map.
//
// Usage:
//   req_ch carries one request item (allocate, free or query); rsp_ch returns
//   exactly one response item per request, in order. Items move when valid
//   and ready are both high at a rising clock edge.
//   The block takes one request at a time. After acceptance the sequencer
//   inspects one slot bit per cycle through the single port of the slot map:
//   free, query and unused codes look only at the addressed slot, while an
//   allocate walks from the search hint until it finds a free slot or has
//   inspected every slot (the table is full). The response is valid the
//   cycle after the last work cycle, and req_ch.ready returns then.
//   The response sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls and the register is still full
//   when the following request finishes, the sequencer holds in its last
//   work cycle without changing any state until the register frees up.
//   Synchronous reset frees every slot at once, clears the hint and the used
//   count and drops any pending response.
module next_fit_slot_allocator_core import nfsa_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   nfsa_req_if.sink   req_ch,
   nfsa_rsp_if.source rsp_ch
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int WIDE_W = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic {ST_IDLE, ST_WORK} state_type;

   state_type             state_ff, state_in;
   logic [REQ_TYPE_W-1:0] op_ff, op_in;
   logic                  in_range_ff, in_range_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      steps_ff, steps_in;
   logic [IDX_W-1:0]      hint_ff, hint_in;
   logic [CNT_W-1:0]      used_total_ff, used_total_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [SLOT_IDX_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic                  rsp_used_ff, rsp_used_in;
   logic [USED_CNT_W-1:0] rsp_count_ff, rsp_count_in;

   map_wr_type            map_wr;
   logic                  map_rd_bit;
   logic                  rsp_free;
   logic                  commit;

   nfsa_slot_map #(.SLOT_COUNT(SLOT_COUNT)) u_slot_map (
      .clock  (clock),
      .reset  (reset),
      .addr   (pos_ff),
      .wr     (map_wr),
      .rd_bit (map_rd_bit)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      logic             finish;
      logic             res_status;
      logic             res_used;
      logic [IDX_W-1:0] res_grant;
      logic             wr_en;
      logic             wr_set;
      logic [IDX_W-1:0] next_pos;
      logic [CNT_W-1:0] total_after;
      logic [IDX_W-1:0] hint_after;

      state_in       = state_ff;
      op_in          = op_ff;
      in_range_in    = in_range_ff;
      pos_in         = pos_ff;
      steps_in       = steps_ff;
      hint_in        = hint_ff;
      used_total_in  = used_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_count_in   = rsp_count_ff;
      map_wr         = '0;
      commit         = 1'b0;

      finish      = 1'b1;
      res_status  = STATUS_OK;
      res_used    = 1'b0;
      res_grant   = '0;
      wr_en       = 1'b0;
      wr_set      = 1'b0;
      next_pos    = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
      total_after = used_total_ff;
      hint_after  = hint_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in       = req_ch.req_type;
               in_range_in = WIDE_W'(req_ch.slot_index) < WIDE_W'(SLOT_COUNT);
               pos_in      = (req_ch.req_type == REQ_ALLOC) ? hint_ff
                                                            : IDX_W'(req_ch.slot_index);
               steps_in    = '0;
               state_in    = ST_WORK;
            end
         end
         ST_WORK: begin
            case (op_ff)
               REQ_ALLOC: begin
                  if (!map_rd_bit) begin
                     res_grant   = pos_ff;
                     wr_en       = 1'b1;
                     wr_set      = 1'b1;
                     total_after = used_total_ff + 1'b1;
                     hint_after  = next_pos;
                  end else if (steps_ff == LAST_IDX) begin
                     res_status = STATUS_FULL;
                  end else begin
                     finish = 1'b0;
                  end
               end
               REQ_FREE: begin
                  if (in_range_ff && map_rd_bit) begin
                     res_used = 1'b1;
                     wr_en    = 1'b1;
                     wr_set   = 1'b0;
                     if (used_total_ff != '0) begin
                        total_after = used_total_ff - 1'b1;
                     end
                  end
               end
               REQ_QUERY: begin
                  res_used = in_range_ff && map_rd_bit;
               end
               default: ;
            endcase

            if (!finish) begin
               // advance the scan one slot
               pos_in   = next_pos;
               steps_in = steps_ff + 1'b1;
            end else if (rsp_free) begin
               commit         = 1'b1;
               map_wr.en      = wr_en;
               map_wr.set     = wr_set;
               used_total_in  = total_after;
               hint_in        = hint_after;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status;
               rsp_granted_in = SLOT_IDX_W'(res_grant);
               rsp_used_in    = res_used;
               rsp_count_in   = USED_CNT_W'(total_after);
               state_in       = ST_IDLE;
            end
            // otherwise hold until the response register drains
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hint_ff       <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hint_ff       <= hint_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      in_range_ff    <= in_range_in;
      pos_ff         <= pos_in;
      steps_ff       <= steps_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.granted_slot = rsp_granted_ff;
   assign rsp_ch.slot_used    = rsp_used_ff;
   assign rsp_ch.used_count   = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_total_ff <= CNT_W'(SLOT_COUNT))
      else $error("used count exceeds table size");

   a_hint_bound: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= LAST_IDX)
      else $error("search hint outside table");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while previous item still in work");

   a_full_means_all_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_FULL) |->
         rsp_ch.used_count == USED_CNT_W'(SLOT_COUNT))
      else $error("full status reported with free slots left");

   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_ch.valid && req_ch.ready)
      else $error("finished item did not reach the response register");

endmodule

FILE: hdl/nfsa_slot_map.sv
// Used/free bitmap of the slot table: one flop per slot, cleared by reset,
// one shared address for the read and the write. Depends on nfsa_pkg.
module nfsa_slot_map import nfsa_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   localparam int IDX_W = $clog2(SLOT_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] addr,
   input  map_wr_type       wr,
   output logic             rd_bit
);

   logic [SLOT_COUNT-1:0] used_ff;
   logic [SLOT_COUNT-1:0] used_in;

   always_comb begin
      used_in = used_ff;
      if (wr.en) begin
         used_in[addr] = wr.set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign rd_bit = used_ff[addr];

endmodule

FILE: tb/nfsa_tb_pkg.sv
// Checking side of the next-fit slot allocator bench: the result record and a
// scoreboard that mirrors the slot table. Depends on nfsa_pkg.
package nfsa_tb_pkg;
   import nfsa_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;
   // request code the block does not define; it must leave the table alone
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic                  status;
      logic [SLOT_IDX_W-1:0] granted_slot;
      logic                  slot_used;
      logic [USED_CNT_W-1:0] used_count;
   } slot_result_type;

   class slot_table_scoreboard;
      logic [SLOTS-1:0] used_map;
      int unsigned      search_hint;
      int unsigned      used_total;
      slot_result_type  pending_results[$];
      int unsigned      failures;

      function new();
         used_map    = '0;
         search_hint = 0;
         used_total  = 0;
         failures    = 0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      // advance the mirrored table by one request and return its result
      function slot_result_type predict_slot_request(logic [REQ_TYPE_W-1:0] kind,
                                                     logic [SLOT_IDX_W-1:0] idx);
         slot_result_type r;
         int unsigned     pos;
         bit              found;
         r     = '0;
         pos   = search_hint;
         found = 1'b0;
         case (kind)
            REQ_ALLOC: begin
               for (int n = 0; n < SLOTS && !found; n++) begin
                  if (!used_map[pos]) found = 1'b1;
                  else pos = (pos + 1) % SLOTS;
               end
               if (found) begin
                  used_map[pos]  = 1'b1;
                  used_total++;
                  search_hint    = (pos + 1) % SLOTS;
                  r.granted_slot = SLOT_IDX_W'(pos);
               end else begin
                  r.status = STATUS_FULL;
               end
            end
            REQ_FREE: begin
               if (idx < SLOTS && used_map[idx]) begin
                  r.slot_used   = 1'b1;
                  used_map[idx] = 1'b0;
                  if (used_total > 0) used_total--;
               end
            end
            REQ_QUERY: begin
               r.slot_used = (idx < SLOTS) && used_map[idx];
            end
            default: ;
         endcase
         r.used_count = USED_CNT_W'(used_total);
         return r;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [SLOT_IDX_W-1:0] idx);
         pending_results.push_back(predict_slot_request(kind, idx));
      endfunction

      function void check_response(slot_result_type got);
         slot_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: status %0d granted %0d used %0d count %0d",
                             got.status, got.granted_slot, got.slot_used, got.used_count));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.granted_slot !== want.granted_slot ||
             got.slot_used !== want.slot_used || got.used_count !== want.used_count)
            report($sformatf({"result mismatch: expected status %0d granted %0d used %0d ",
                              "count %0d, got status %0d granted %0d used %0d count %0d"},
                             want.status, want.granted_slot, want.slot_used, want.used_count,
                             got.status, got.granted_slot, got.slot_used, got.used_count));
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // first used slot from a random start, or that start if the table is empty
      function logic [SLOT_IDX_W-1:0] pick_used_slot();
         int unsigned start;
         start = $urandom_range(0, SLOTS - 1);
         for (int n = 0; n < SLOTS; n++)
            if (used_map[(start + n) % SLOTS]) return SLOT_IDX_W'((start + n) % SLOTS);
         return SLOT_IDX_W'(start);
      endfunction
   endclass

endpackage

FILE: tb/next_fit_slot_allocator_core_test.sv
// Top of the next-fit slot allocator bench: clock, reset, paced request driver,
// stalling response sink and monitors. Depends on nfsa_pkg, nfsa_if.sv, nfsa_tb_pkg.
module next_fit_slot_allocator_core_test;
   import nfsa_pkg::*;
   import nfsa_tb_pkg::*;

   typedef enum int unsigned {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} phase_type;

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic rx_ready = 1'b0;

   nfsa_req_if req_ch ();
   nfsa_rsp_if rsp_ch ();

   assign rsp_ch.ready = rx_ready;

   slot_table_scoreboard slot_sb = new();

   int unsigned burst_left = 0;
   int unsigned max_gap    = 8;
   int unsigned sent       = 0;
   int unsigned rx_cycle   = 0;
   int unsigned rx_mode    = 0;

   next_fit_slot_allocator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         slot_sb.note_request(req_ch.req_type, req_ch.slot_index);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         slot_sb.check_response({rsp_ch.status, rsp_ch.granted_slot,
                                 rsp_ch.slot_used, rsp_ch.used_count});
   end

   // periodically switch to a random stall pattern; the last one holds ready low in periodic runs
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
         0: rx_ready <= 1'b1;
         1: rx_ready <= 1'($urandom_range(0, 1));
         2: rx_ready <= (rx_cycle % 4 == 0);
         default: rx_ready <= (rx_cycle % 50) >= 35;
      endcase
   end

   task automatic send_item(input logic [REQ_TYPE_W-1:0] kind,
                            input logic [SLOT_IDX_W-1:0] idx);
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.slot_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic send_paced(input logic [REQ_TYPE_W-1:0] kind,
                             input logic [SLOT_IDX_W-1:0] idx);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      send_item(kind, idx);
   endtask

   // hold off until every outstanding item has been answered
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (slot_sb.pending() != 0);
      burst_left = 0;
   endtask

   task automatic run_phase(input phase_type phase, input int unsigned count);
      int unsigned             roll;
      int unsigned             alloc_lim;
      int unsigned             free_lim;
      logic [REQ_TYPE_W-1:0]   kind;
      logic [SLOT_IDX_W-1:0]   idx;
      case (phase)
         PHASE_FILL:  begin alloc_lim = 85; free_lim = 92; end
         PHASE_DRAIN: begin alloc_lim = 15; free_lim = 75; end
         default:     begin alloc_lim = 45; free_lim = 75; end
      endcase
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_lim)     kind = REQ_ALLOC;
         else if (roll < free_lim) kind = REQ_FREE;
         else if (roll < 95)       kind = REQ_QUERY;
         else                      kind = REQ_UNUSED;
         idx = SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
         if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 1) ? SLOT_IDX_W'(SLOTS - 1) : '0;
         // aim most frees and queries at a slot that is actually held
         if ((kind == REQ_FREE || kind == REQ_QUERY) && $urandom_range(0, 3) != 0)
            idx = slot_sb.pick_used_slot();
         send_paced(kind, idx);
      end
   endtask

   initial begin
      phase_type phase;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_ALLOC;
      req_ch.slot_index <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(REQ_ALLOC, 5'd31);
      send_item(REQ_ALLOC, 5'd0);
      send_item(REQ_QUERY, 5'd0);
      send_item(REQ_QUERY, 5'd31);
      send_item(REQ_FREE, 5'd31);     // free of a slot that is already free
      send_item(REQ_FREE, 5'd0);
      send_item(REQ_QUERY, 5'd0);
      send_item(REQ_UNUSED, 5'd31);
      send_item(REQ_UNUSED, 5'd0);
      send_item(REQ_ALLOC, 5'd0);     // hint has moved past the freed slot
      send_item(REQ_QUERY, 5'd2);
      send_item(REQ_FREE, 5'd1);
      send_item(REQ_FREE, 5'd2);
      send_item(REQ_ALLOC, 5'd21);
      send_item(REQ_QUERY, 5'd3);
      send_item(REQ_FREE, 5'd3);
      send_item(REQ_QUERY, 5'd31);
      send_item(REQ_UNUSED, 5'd21);
      send_item(REQ_FREE, 5'd10);
      send_item(REQ_ALLOC, 5'd10);
      wait_drained();

      phase = PHASE_FILL;
      while (sent < 700) begin
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
         run_phase(phase, $urandom_range(50, 90));
         if (phase == PHASE_FILL || $urandom_range(0, 1) == 0) wait_drained();
         case (phase)
            PHASE_FILL:  phase = PHASE_MIXED;
            PHASE_MIXED: phase = PHASE_DRAIN;
            default:     phase = PHASE_FILL;
         endcase
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (slot_sb.pending() != 0);
      repeat (40) @(posedge clock);
      if (slot_sb.failures == 0 && slot_sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
